/* src/assert_macros.svh */
// assertion macros used by the mailbox request queue control rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define MRQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define MRQ_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MRQ_ASSERT(label, clk, rst_n, prop, msg)
`define MRQ_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

/* src/mrq_pkg.sv */
// types and codes of the mailbox request queue
`default_nettype none
package mrq_pkg;
    localparam int ADDR_W   = 32;
    localparam int TYPE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = ADDR_W + 1;

    // request types
    localparam logic [TYPE_W-1:0] REQ_SUBMIT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_ACK    = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_REPLY  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd2;

    // acknowledge credit values
    localparam logic signed [1:0] CRED_NEG  = -2'sd1;
    localparam logic signed [1:0] CRED_ZERO = 2'sd0;
    localparam logic signed [1:0] CRED_ONE  = 2'sd1;
    localparam logic signed [1:0] CRED_BAD  = -2'sd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                send_valid;
        logic [ADDR_W-1:0]   send_addr;
        logic                relaunch_done;
    } t_result;
endpackage
`default_nettype wire

/* src/mrq_ram.sv */
// generic single write, single read ram with registered read data
`default_nettype none
module mrq_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

/* src/mrq_ctrl.sv */
// ring pointers, credit and relaunch control around the ring ram
`default_nettype none
`include "assert_macros.svh"
module mrq_ctrl
    import mrq_pkg::*;
#(
    parameter int RING_DEPTH = 48
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request beat
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [TYPE_W-1:0]                  i_req_type,
    input  wire logic [ADDR_W-1:0]                  i_request_addr,
    input  wire logic                               i_is_relaunch,
    // ring ram
    output logic                                    o_wr_en,
    output logic [$clog2(RING_DEPTH)-1:0]           o_wr_addr,
    output logic [ENTRY_W-1:0]                      o_wr_data,
    output logic                                    o_rd_en,
    output logic [$clog2(RING_DEPTH)-1:0]           o_rd_addr,
    input  wire logic [ENTRY_W-1:0]                 i_rd_data,
    // result towards the output register
    input  wire logic                               i_res_free,
    output logic                                    o_res_valid,
    output t_result                                 o_res,
    output logic [$clog2(RING_DEPTH+1)-1:0]         o_res_count
);
    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_DEPTH - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic                r_state, n_state;
    logic [TYPE_W-1:0]   r_type, n_type;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_sub_ok, n_sub_ok;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]    r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic signed [1:0]   r_credit, n_credit;
    logic                r_pend, n_pend;
    logic [ADDR_W-1:0]   r_saved, n_saved;
    logic                r_fwd, n_fwd;
    logic [ENTRY_W-1:0]  r_fwd_data;

    logic                acc, is_sub, busy, full, sub_ok;
    logic                go, try_send, sent, reply_hit, done;
    logic [ENTRY_W-1:0]  head;
    logic signed [1:0]   cred_up, cred_base;
    logic [STATUS_W-1:0] sub_status;

    // accept side: a submit that is not busy or full writes the ring straight away, head read issued
    always_comb begin
        acc        = i_in_valid && (r_state == S_IDLE);
        is_sub     = (i_req_type == REQ_SUBMIT);
        busy       = i_is_relaunch && r_pend;
        full       = (r_occ == DEPTH_CNT);
        sub_status = busy ? ST_BUSY : (full ? ST_FULL : ST_OK);
        sub_ok     = acc && is_sub && !busy && !full;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_wr_en    = sub_ok;
    assign o_wr_addr  = r_wr_idx;
    assign o_wr_data  = {i_is_relaunch, i_request_addr};
    assign o_rd_en    = acc;
    assign o_rd_addr  = r_rd_idx;

    // evaluate side: head entry available in the cycle after accept
    always_comb begin
        go        = (r_state == S_EVAL) && i_res_free;
        head      = r_fwd ? r_fwd_data : i_rd_data;
        cred_up   = (r_credit < CRED_ONE) ? (r_credit + CRED_ONE) : r_credit;
        reply_hit = (r_type == REQ_REPLY) && (r_addr != '0) && r_pend &&
                    (r_addr == r_saved);
        done      = (r_type == REQ_ACK) && (cred_up > CRED_ZERO) && r_pend;
        try_send  = ((r_type == REQ_SUBMIT) && r_sub_ok && (r_credit > CRED_ZERO)) ||
                    ((r_type == REQ_ACK) && (cred_up > CRED_ZERO));
        sent      = try_send && (r_occ != '0) && (head[ADDR_W-1:0] != '0);
        cred_base = ((r_type == REQ_ACK) || reply_hit) ? cred_up : r_credit;
    end

    always_comb begin
        n_state  = r_state;
        n_type   = r_type;
        n_addr   = r_addr;
        n_status = r_status;
        n_sub_ok = r_sub_ok;
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        n_occ    = r_occ;
        n_credit = r_credit;
        n_pend   = r_pend;
        n_saved  = r_saved;
        n_fwd    = r_fwd;
        if (acc) begin
            n_state  = S_EVAL;
            n_type   = i_req_type;
            n_addr   = i_request_addr;
            n_status = is_sub ? sub_status : ST_OK;
            n_sub_ok = sub_ok;
            // empty ring: the head is the entry written this cycle
            n_fwd    = sub_ok && (r_wr_idx == r_rd_idx);
            if (sub_ok) begin
                n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
                n_occ    = r_occ + 1'b1;
                if (i_is_relaunch) begin
                    n_pend  = 1'b1;
                    n_saved = i_request_addr;
                end
            end
        end else if (go) begin
            n_state  = S_IDLE;
            n_credit = cred_base;
            if (done || reply_hit) begin
                n_pend = 1'b0;
            end
            if (sent) begin
                // a send resets the credit to zero, or to minus one for a relaunch entry
                n_credit = head[ADDR_W] ? CRED_NEG : CRED_ZERO;
                n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
                n_occ    = r_occ - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_type   <= REQ_SUBMIT;
            r_status <= ST_OK;
            r_sub_ok <= 1'b0;
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_occ    <= '0;
            r_credit <= CRED_ONE;
            r_pend   <= 1'b0;
            r_saved  <= '0;
            r_fwd    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_type   <= n_type;
            r_status <= n_status;
            r_sub_ok <= n_sub_ok;
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_occ    <= n_occ;
            r_credit <= n_credit;
            r_pend   <= n_pend;
            r_saved  <= n_saved;
            r_fwd    <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (acc) begin
            r_fwd_data <= o_wr_data;
        end
    end

    always_comb begin
        o_res_valid          = go;
        o_res.status         = (r_type == REQ_SUBMIT) ? r_status : ST_OK;
        o_res.send_valid     = sent;
        o_res.send_addr      = sent ? head[ADDR_W-1:0] : '0;
        o_res.relaunch_done  = done;
        o_res_count          = sent ? (r_occ - 1'b1) : r_occ;
    end

    `MRQ_ASSERT(a_occ_bound, i_clk, i_rst_n, r_occ <= DEPTH_CNT, "ring occupancy overflow")
    `MRQ_NEVER(a_credit_range, i_clk, i_rst_n, r_credit == CRED_BAD, "credit below -1")
    `MRQ_ASSERT(a_send_nonempty, i_clk, i_rst_n, go && sent |-> r_occ != '0, "send from empty ring")
    `MRQ_ASSERT(a_accept_eval, i_clk, i_rst_n, acc |=> r_state == S_EVAL, "accept without evaluate")
endmodule
`default_nettype wire

/* src/mailbox_request_queue_top.sv */
// mailbox request queue: ring ram, control and result register
// a request beat is taken in idle, the ring ram read registers the head entry and the evaluate
// state updates credit and pointers and loads the result into the output register; a new
//   request is taken only after that update, and a held result stalls the update
// reset: synchronous, clears pointers, count, relaunch state and sets credit to one
// ring contents are undefined after reset and an entry is only used once written
`default_nettype none
module mailbox_request_queue_top
    import mrq_pkg::*;
#(
    parameter int RING_DEPTH = 48
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [TYPE_W-1:0]               i_req_type,
    input  wire logic [ADDR_W-1:0]               i_request_addr,
    input  wire logic                            i_is_relaunch,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [STATUS_W-1:0]                  o_status,
    output logic                                 o_send_valid,
    output logic [ADDR_W-1:0]                    o_send_addr,
    output logic                                 o_relaunch_done,
    output logic [$clog2(RING_DEPTH+1)-1:0]      o_queue_count
);
    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    // ring ram port signals
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    // result from control, before the output register
    logic               res_valid;
    t_result            res;
    logic [CNT_W-1:0]   res_count;
    logic               res_free;

    // output register, parts the result beat from the control
    logic               r_out_valid;
    t_result            r_out_res;
    logic [CNT_W-1:0]   r_out_count;

    // ring entries: address in the low bits, relaunch mark on top
    mrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mrq_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_request_addr (i_request_addr),
        .i_is_relaunch  (i_is_relaunch),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .i_res_free     (res_free),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .o_res_count    (res_count)
    );

    // the register can take a new result when empty or being drained
    assign res_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= res_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (res_free && res_valid) begin
            r_out_res   <= res;
            r_out_count <= res_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_res.status;
    assign o_send_valid    = r_out_res.send_valid;
    assign o_send_addr     = r_out_res.send_addr;
    assign o_relaunch_done = r_out_res.relaunch_done;
    assign o_queue_count   = r_out_count;
endmodule
`default_nettype wire
